// ----- rtl/tgx_pkg.sv -----
// shared types, constants and an index helper for the twisted gfsr keystream core
package tgx_pkg;

  localparam int unsigned Words   = 25;
  localparam int unsigned TapOfs  = 7;
  localparam int unsigned AddrW   = $clog2(Words);

  localparam logic [31:0] TwistConst = 32'h8EBF_D028;
  localparam logic [31:0] TemperB    = 32'h2B5B_2500;
  localparam logic [31:0] TemperC    = 32'hDB8B_0000;

  localparam logic OpSeed = 1'b0;
  localparam logic OpData = 1'b1;

  typedef logic [AddrW-1:0] idx_t;
  typedef logic [31:0]      word_t;

  typedef struct packed {
    logic  en;
    idx_t  addr;
    word_t data;
  } wr_req_t;

  // modular add of a small offset to a store index
  function automatic idx_t wrap_add(idx_t a, idx_t b);
    logic [AddrW:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= (AddrW+1)'(Words)) begin
      s = s - (AddrW+1)'(Words);
    end
    return s[AddrW-1:0];
  endfunction

endpackage

// ----- rtl/tgx_word_store.sv -----
// word store: one registered read port, one write port, per-entry valid bits
module tgx_word_store (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  tgx_pkg::idx_t    rd_addr_i,
  output tgx_pkg::word_t   rd_data_o,
  input  tgx_pkg::wr_req_t wr_req_i
);
  import tgx_pkg::*;

  word_t             mem [Words];
  logic [Words-1:0]  valid_q;
  word_t             rd_data_q;
  logic              rd_valid_q;

  // payload array, no reset
  always_ff @(posedge clk_i) begin
    if (wr_req_i.en) begin
      mem[wr_req_i.addr] <= wr_req_i.data;
    end
    rd_data_q <= mem[rd_addr_i];
  end

  // never-written entries read as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (wr_req_i.en) begin
        valid_q[wr_req_i.addr] <= 1'b1;
      end
      rd_valid_q <= valid_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_valid_q ? rd_data_q : '0;

endmodule

// ----- rtl/twisted_gfsr_keystream_xor_core.sv -----
// top level: keystream xor core with sequencer around the word store
//
// Keystream cipher on a 25-word twisted GFSR with tempered output. An input
// transfer with tuser = 0 reseeds the store from the seed register (word 0
// is the low half of the seed, each later word the low half of the next
// xorshift 13/7/17 step) and returns a zero result; with tuser = 1 it
// advances the generator once and XORs up to four message bytes (first byte
// in bits 31:24) with the tempered word, unused lanes reading zero. A byte
// count of zero returns zero and leaves the generator alone; counts above
// four act as four. Every input transfer yields exactly one output transfer.
// One item at a time. A data item passes from acceptance through ST_RD_NXT,
// ST_RD_TAP and ST_CALC to ST_FIN, a zero-count item goes straight to ST_FIN,
// a seed item through ST_SEED (one store write per word) to ST_FIN; ST_FIN
// loads the output register once it is free. The input is ready again in the
// cycle after the output register is loaded, so no new item is taken before
// the last is through. The order comes from the single store read port:
// the three words of a generator step are fetched one after the other, each
// read registered. Before any seed the store reads as zero.
// The seed register may be written only while no item is in flight.
module twisted_gfsr_keystream_xor_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [63:0] cfg_wdata_i,      // seed_value
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,     // data_word[31:0], byte_count[34:32], zero pad
  input  logic [0:0]  s_axis_tuser,     // operation
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata      // cipher_word[31:0], valid_bytes[34:32], zero pad
);
  import tgx_pkg::*;

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_SEED   = 6'b000010,
    ST_RD_NXT = 6'b000100,
    ST_RD_TAP = 6'b001000,
    ST_CALC   = 6'b010000,
    ST_FIN    = 6'b100000
  } state_e;

  // output tempering
  function automatic word_t temper(word_t x);
    word_t y;
    y = x;
    y = y ^ (y >> 11);
    y = y ^ ((y << 7) & TemperB);
    y = y ^ ((y << 15) & TemperC);
    y = y ^ (y >> 18);
    return y;
  endfunction

  // one step of the 64-bit xorshift used for seeding
  function automatic logic [63:0] xorshift(logic [63:0] v);
    logic [63:0] s;
    s = v;
    s = s ^ (s << 13);
    s = s ^ (s >> 7);
    s = s ^ (s << 17);
    return s;
  endfunction

  // byte-lane mask, lanes filled from the top
  function automatic word_t lane_mask(logic [2:0] cnt);
    word_t m;
    case (cnt)
      3'd0:    m = 32'h0000_0000;
      3'd1:    m = 32'hFF00_0000;
      3'd2:    m = 32'hFFFF_0000;
      3'd3:    m = 32'hFFFF_FF00;
      default: m = 32'hFFFF_FFFF;
    endcase
    return m;
  endfunction

  state_e      state_q, state_d;
  logic [63:0] seed_q;
  idx_t        pos_q, pos_d;
  idx_t        seed_idx_q, seed_idx_d;
  logic [63:0] sv_q, sv_d;

  // item payload captured at acceptance
  word_t       data_q, data_d;
  logic [2:0]  cnt_q, cnt_d;

  // partial twist input gathered across reads
  logic        hi_q, hi_d;
  word_t       mix_q, mix_d;

  // finished result waiting for the output register
  word_t       res_word_q, res_word_d;
  logic [2:0]  res_cnt_q, res_cnt_d;

  logic        out_valid_q, out_valid_d;
  word_t       out_word_q, out_word_d;
  logic [2:0]  out_cnt_q, out_cnt_d;

  idx_t        rd_addr;
  word_t       rd_data;
  wr_req_t     wr_req;

  idx_t        pos_nxt;
  idx_t        pos_tap;
  word_t       twist;
  word_t       new_word;

  logic        in_xfer;
  logic        out_free;
  logic        in_op;
  word_t       in_data;
  logic [2:0]  in_cnt;
  logic [2:0]  in_cnt_sat;

  assign in_op      = s_axis_tuser[0];
  assign in_data    = s_axis_tdata[31:0];
  assign in_cnt     = s_axis_tdata[34:32];
  assign in_cnt_sat = (in_cnt > 3'd4) ? 3'd4 : in_cnt;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid_q || m_axis_tready;

  assign pos_nxt = wrap_add(pos_q, idx_t'(1));
  assign pos_tap = wrap_add(pos_q, idx_t'(TapOfs));

  // twist of the gathered mix word, xored with the tap word arriving now
  assign twist    = mix_q[0] ? ((mix_q >> 1) ^ TwistConst) : (mix_q >> 1);
  assign new_word = rd_data ^ twist;

  tgx_word_store u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data),
    .wr_req_i  (wr_req)
  );

  always_comb begin
    state_d     = state_q;
    pos_d       = pos_q;
    seed_idx_d  = seed_idx_q;
    sv_d        = sv_q;
    data_d      = data_q;
    cnt_d       = cnt_q;
    hi_d        = hi_q;
    mix_d       = mix_q;
    res_word_d  = res_word_q;
    res_cnt_d   = res_cnt_q;
    out_valid_d = out_valid_q;
    out_word_d  = out_word_q;
    out_cnt_d   = out_cnt_q;
    rd_addr     = pos_q;
    wr_req      = '{en: 1'b0, addr: pos_q, data: new_word};

    if (out_valid_q && m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        // read of word k is issued here, so it lands in ST_RD_NXT
        if (in_xfer) begin
          data_d = in_data;
          cnt_d  = in_cnt_sat;
          if (in_op == OpSeed) begin
            sv_d       = seed_q;
            seed_idx_d = '0;
            state_d    = ST_SEED;
          end else if (in_cnt_sat == 3'd0) begin
            res_word_d = '0;
            res_cnt_d  = '0;
            state_d    = ST_FIN;
          end else begin
            state_d = ST_RD_NXT;
          end
        end
      end
      ST_SEED: begin
        wr_req = '{en: 1'b1, addr: seed_idx_q, data: sv_q[31:0]};
        sv_d   = xorshift(sv_q);
        if (seed_idx_q == idx_t'(Words - 1)) begin
          pos_d      = '0;
          res_word_d = '0;
          res_cnt_d  = '0;
          state_d    = ST_FIN;
        end else begin
          seed_idx_d = seed_idx_q + idx_t'(1);
        end
      end
      ST_RD_NXT: begin
        rd_addr = pos_nxt;
        hi_d    = rd_data[31];
        state_d = ST_RD_TAP;
      end
      ST_RD_TAP: begin
        rd_addr = pos_tap;
        mix_d   = {hi_q, rd_data[30:0]};
        state_d = ST_CALC;
      end
      ST_CALC: begin
        rd_addr    = pos_tap;
        wr_req     = '{en: 1'b1, addr: pos_q, data: new_word};
        pos_d      = pos_nxt;
        res_word_d = (data_q ^ temper(new_word)) & lane_mask(cnt_q);
        res_cnt_d  = cnt_q;
        state_d    = ST_FIN;
      end
      ST_FIN: begin
        // hand over once the output register is free
        if (out_free) begin
          out_valid_d = 1'b1;
          out_word_d  = res_word_q;
          out_cnt_d   = res_cnt_q;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      seed_q      <= '0;
      pos_q       <= '0;
      seed_idx_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pos_q       <= pos_d;
      seed_idx_q  <= seed_idx_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        seed_q <= cfg_wdata_i;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    sv_q       <= sv_d;
    data_q     <= data_d;
    cnt_q      <= cnt_d;
    hi_q       <= hi_d;
    mix_q      <= mix_d;
    res_word_q <= res_word_d;
    res_cnt_q  <= res_cnt_d;
    out_word_q <= out_word_d;
    out_cnt_q  <= out_cnt_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'b0, out_cnt_q, out_word_q};

endmodule

// ----- bench/tb_top.sv -----
`timescale 1ns / 100ps
// self-checking bench for the twisted gfsr keystream xor core
module tb_top;
  import tgx_pkg::*;

  typedef struct {
    logic [31:0] cipher;
    logic [2:0]  nbytes;
  } cipher_res_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [63:0] cfg_wdata_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata;   // data_word[31:0], byte_count[34:32], zero pad
  logic [0:0]  s_axis_tuser;   // operation
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [39:0] m_axis_tdata;   // cipher_word[31:0], valid_bytes[34:32], zero pad

  // generator copy kept by the bench
  logic [31:0] ks_store [Words];
  int unsigned ks_pos;
  logic [63:0] seed_reg;

  cipher_res_t pending_ciphers[$];
  int unsigned fail_count   = 0;
  int unsigned rx_hold_left = 0;
  bit          steady_flow  = 1'b0;

  twisted_gfsr_keystream_xor_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // fill the store from the seed with a 64-bit xorshift 13/7/17 run
  function automatic void reseed_store();
    logic [63:0] sv;
    sv = seed_reg;
    ks_store[0] = sv[31:0];
    for (int i = 1; i < Words; i++) begin
      sv ^= sv << 13;
      sv ^= sv >> 7;
      sv ^= sv << 17;
      ks_store[i] = sv[31:0];
    end
    ks_pos = 0;
  endfunction

  // one twist step, then tempering of the new word
  function automatic logic [31:0] next_keystream();
    int unsigned k, nxt, tap;
    logic [31:0] mix, y;
    k   = ks_pos % Words;
    nxt = (k + 1) % Words;
    tap = (k + TapOfs) % Words;
    mix = {ks_store[k][31], ks_store[nxt][30:0]};
    y   = ks_store[tap] ^ (mix >> 1) ^ (mix[0] ? TwistConst : 32'h0);
    ks_store[k] = y;
    ks_pos = nxt;
    y ^= y >> 11;
    y ^= (y << 7) & TemperB;
    y ^= (y << 15) & TemperC;
    y ^= y >> 18;
    return y;
  endfunction

  function automatic cipher_res_t predict_cipher(logic [0:0] op, logic [31:0] data,
                                                 logic [2:0] cnt);
    cipher_res_t r;
    logic [2:0]  n;
    logic [31:0] lane_mask;
    r.cipher = 32'h0;
    r.nbytes = 3'd0;
    if (op == OpSeed) begin
      reseed_store();
    end else if (cnt != 3'd0) begin
      // counts above four saturate, a zero count leaves the generator alone
      n = (cnt > 3'd4) ? 3'd4 : cnt;
      lane_mask = 32'hFFFF_FFFF << (8 * (4 - n));
      r.cipher = (data ^ next_keystream()) & lane_mask;
      r.nbytes = n;
    end
    return r;
  endfunction

  // receiver: random stalls, or a long counted hold-off when asked
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rx_hold_left != 0) begin
        rx_hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= steady_flow || ($urandom_range(99) >= 11);
      end
    end
  end

  // compare each result transfer with the oldest prediction
  always @(posedge clk_i) begin : result_check
    cipher_res_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_ciphers.size() == 0) begin
        $error("unexpected result transfer, tdata %h", m_axis_tdata);
        fail_count++;
      end else begin
        want = pending_ciphers.pop_front();
        if (m_axis_tdata[31:0] !== want.cipher) begin
          $error("cipher_word: expected %h, got %h", want.cipher, m_axis_tdata[31:0]);
          fail_count++;
        end
        if (m_axis_tdata[34:32] !== want.nbytes) begin
          $error("valid_bytes: expected %0d, got %0d", want.nbytes, m_axis_tdata[34:32]);
          fail_count++;
        end
        if (m_axis_tdata[39:35] !== 5'd0) begin
          $error("pad: expected 0, got %h", m_axis_tdata[39:35]);
          fail_count++;
        end
      end
    end
  end

  // one input transfer, then the prediction for it is queued
  task automatic send_item(input logic [0:0] op, input logic [31:0] data,
                           input logic [2:0] cnt);
    if (!steady_flow && $urandom_range(99) < 11) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {5'b0, cnt, data};
    do @(posedge clk_i); while (!s_axis_tready);
    pending_ciphers.push_back(predict_cipher(op, data, cnt));
  endtask

  task automatic send_random_item(input int unsigned seed_pct);
    logic [0:0]  op;
    logic [2:0]  cnt;
    logic [31:0] data;
    op   = ($urandom_range(99) < seed_pct) ? OpSeed : OpData;
    cnt  = ($urandom_range(99) < 85) ? 3'($urandom_range(1, 4)) : 3'($urandom_range(0, 7));
    data = $urandom();
    send_item(op, data, cnt);
  endtask

  // stop offering and let every predicted result come back
  task automatic wait_all_results();
    s_axis_tvalid <= 1'b0;
    while (pending_ciphers.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // seed register write, only while the core is idle
  task automatic write_seed(input logic [63:0] v);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    seed_reg = v;
  endtask

  // data on the cleared store, then a seed from the reset value of the register
  task automatic test_unseeded();
    send_item(OpData, 32'hFFFF_FFFF, 3'd4);
    send_item(OpData, 32'h1234_5678, 3'd1);
    send_item(OpData, 32'hDEAD_BEEF, 3'd0);
    send_item(OpSeed, 32'h0, 3'd0);
    send_item(OpData, 32'hA5A5_A5A5, 3'd4);
    wait_all_results();
  endtask

  // every byte count, saturation, zero count, extreme seeds and data
  task automatic test_field_extremes();
    write_seed(64'hFFFF_FFFF_FFFF_FFFF);
    send_item(OpSeed, 32'hFFFF_FFFF, 3'd7);
    send_item(OpData, 32'h0000_0000, 3'd4);
    send_item(OpData, 32'hFFFF_FFFF, 3'd4);
    send_item(OpData, $urandom(), 3'd1);
    send_item(OpData, $urandom(), 3'd2);
    send_item(OpData, $urandom(), 3'd3);
    send_item(OpData, 32'hFFFF_FFFF, 3'd0);
    send_item(OpData, $urandom(), 3'd5);
    send_item(OpData, $urandom(), 3'd6);
    send_item(OpData, 32'hFFFF_FFFF, 3'd7);
    wait_all_results();
    write_seed(64'h0000_0000_0000_0001);
    send_item(OpSeed, 32'h0, 3'd4);
    send_item(OpData, $urandom(), 3'd4);
    send_item(OpData, $urandom(), 3'd2);
    wait_all_results();
    write_seed(64'h8000_0000_0000_0000);
    send_item(OpSeed, $urandom(), 3'd1);
    send_item(OpData, $urandom(), 3'd4);
    send_item(OpSeed, 32'h0, 3'd0);
    send_item(OpData, $urandom(), 3'd3);
    wait_all_results();
  endtask

  // receiver holds off while the sender keeps offering, so input stalls
  task automatic test_backpressure();
    write_seed({$urandom(), $urandom()});
    send_item(OpSeed, 32'h0, 3'd0);
    rx_hold_left = 300;
    repeat (40) send_random_item(0);
    wait_all_results();
  endtask

  task automatic test_random_phase(input int unsigned n, input logic [63:0] sd,
                                   input bit quiet);
    steady_flow = quiet;
    write_seed(sd);
    send_item(OpSeed, $urandom(), 3'($urandom_range(0, 7)));
    repeat (n) send_random_item(4);
    wait_all_results();
    steady_flow = 1'b0;
  endtask

  initial begin
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = 64'h0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = 40'h0;
    s_axis_tuser  = 1'b0;
    seed_reg      = 64'h0;
    ks_pos        = 0;
    for (int i = 0; i < Words; i++) ks_store[i] = 32'h0;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_unseeded();
    test_field_extremes();
    test_backpressure();
    test_random_phase(240, {$urandom(), $urandom()}, 1'b0);
    test_random_phase(240, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
    test_random_phase(240, {$urandom(), $urandom()}, 1'b0);
    test_random_phase(240, 64'h0000_0000_0000_0000, 1'b0);
    test_random_phase(240, {$urandom(), $urandom()}, 1'b1);
    test_random_phase(240, {$urandom(), $urandom()}, 1'b0);

    repeat (30) @(posedge clk_i);
    if (pending_ciphers.size() != 0) begin
      $error("%0d predicted results never arrived", pending_ciphers.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // hang guard, far beyond the slowest correct run
  initial begin
    #5_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule

// ----- files.f -----
rtl/tgx_pkg.sv
rtl/tgx_word_store.sv
rtl/twisted_gfsr_keystream_xor_core.sv
bench/tb_top.sv
